// ----- hw/rtl/irq_pkg.sv -----
// Shared widths, codes and defaults for the indexed removal queue.
`default_nettype none

package irq_pkg;

   // Payload widths
   localparam int VALUE_W     = 32;
   localparam int POS_W       = 16;
   localparam int STATUS_W    = 2;
   localparam int COUNT_OUT_W = 5;

   // Default queue depth
   localparam int DEPTH_DEFAULT = 16;

   // Request actions
   localparam logic ACT_ENQUEUE = 1'b0;
   localparam logic ACT_REMOVE  = 1'b1;

   // Response status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

endpackage

`default_nettype wire

// ----- hw/rtl/irq_if.sv -----
// Valid/ready channel interfaces for requests and responses.
`default_nettype none

interface irq_req_if import irq_pkg::*;;
   logic                      valid;
   logic                      ready;
   logic                      action;
   logic signed [VALUE_W-1:0] value;
   logic [POS_W-1:0]          position;

   modport source (output valid, action, value, position, input ready);
   modport sink   (input valid, action, value, position, output ready);
endinterface

interface irq_rsp_if import irq_pkg::*;;
   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] removed_value;
   logic [STATUS_W-1:0]       status;
   logic                      is_empty;
   logic [COUNT_OUT_W-1:0]    entry_count;

   modport source (output valid, removed_value, status, is_empty, entry_count, input ready);
   modport sink   (input valid, removed_value, status, is_empty, entry_count, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/indexed_removal_queue_top.sv -----
// Top level of the indexed removal queue: sequencer, count and response register.
//
//  Channel   Dir  Handshake             Payload
//  req_chan  in   valid/ready           action, value, position
//  rsp_chan  out  valid/ready           removed_value, status, is_empty, entry_count
//
// Enqueue and error items hold the block from the transfer cycle to the response load.
// A remove holds it for the transfer cycle, the bit-serial remainder unit (16 steps and
// a done flag), the read of the entry, one close-up move per entry behind it, a last step
// to close up the memory, and the load.
// Synchronous reset empties the queue; no clearing pass runs over the memory.
// A held response stalls only the final load; the next request is taken
// as soon as the previous item has been loaded into the response register.
`default_nettype none

module indexed_removal_queue_top import irq_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  wire logic  clock,
   input  wire logic  reset,
   irq_req_if.sink    req_chan,
   irq_rsp_if.source  rsp_chan
);

   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int ADDR_W = $clog2(DEPTH);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_DIV   = 5'b00010,
      S_GRAB  = 5'b00100,
      S_SHIFT = 5'b01000,
      S_DONE  = 5'b10000
   } state_type;

   state_type               state_ff, state_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [CNT_W-1:0]        idx_ff, idx_in;
   logic [VALUE_W-1:0]      res_removed_ff, res_removed_in;
   logic [STATUS_W-1:0]     res_status_ff, res_status_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]      rsp_removed_ff, rsp_removed_in;
   logic [STATUS_W-1:0]     rsp_status_ff, rsp_status_in;
   logic                    rsp_empty_ff, rsp_empty_in;
   logic [COUNT_OUT_W-1:0]  rsp_count_ff, rsp_count_in;

   logic                    wr_en;
   logic [ADDR_W-1:0]       wr_addr;
   logic [VALUE_W-1:0]      wr_data;
   logic [ADDR_W-1:0]       rd_addr;
   logic [VALUE_W-1:0]      rd_data;

   logic                    rem_start;
   logic [POS_W-1:0]        rem_dividend;
   logic                    rem_done;
   logic [CNT_W-1:0]        rem_result;

   logic                    req_xfer;
   logic                    rsp_load;
   logic [CNT_W-1:0]        idx_plus1;
   logic [CNT_W-1:0]        idx_plus2;
   logic [31:0]             count_wide;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_xfer       = req_chan.valid && req_chan.ready;
   assign rsp_load       = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_chan.ready);
   assign idx_plus1      = idx_ff + CNT_W'(1);
   assign idx_plus2      = idx_ff + CNT_W'(2);
   assign count_wide     = 32'(count_ff);

   // Position 0 and 1 both pick the head
   assign rem_dividend = (req_chan.position == '0) ? '0 : req_chan.position - 1'b1;

   irq_rem #(.DEPTH(DEPTH)) u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (rem_start),
      .dividend  (rem_dividend),
      .divisor   (count_ff),
      .done      (rem_done),
      .remainder (rem_result)
   );

   irq_mem #(.DEPTH(DEPTH)) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Sequencer
   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      idx_in         = idx_ff;
      res_removed_in = res_removed_ff;
      res_status_in  = res_status_ff;
      wr_en          = 1'b0;
      wr_addr        = count_ff[ADDR_W-1:0];
      wr_data        = req_chan.value;
      rd_addr        = idx_ff[ADDR_W-1:0];
      rem_start      = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               res_removed_in = '0;
               res_status_in  = ST_OK;
               if (req_chan.action == ACT_ENQUEUE) begin
                  if (count_ff == CNT_W'(DEPTH)) begin
                     res_status_in = ST_FULL;
                  end else begin
                     wr_en    = 1'b1;
                     count_in = count_ff + CNT_W'(1);
                  end
                  state_in = S_DONE;
               end else if (count_ff == '0) begin
                  res_status_in = ST_EMPTY;
                  state_in      = S_DONE;
               end else begin
                  rem_start = 1'b1;
                  state_in  = S_DIV;
               end
            end
         end
         S_DIV: begin
            // Issue the read of the selected entry as soon as k is known
            if (rem_done) begin
               idx_in   = rem_result;
               rd_addr  = rem_result[ADDR_W-1:0];
               state_in = S_GRAB;
            end
         end
         S_GRAB: begin
            res_removed_in = rd_data;
            rd_addr        = idx_plus1[ADDR_W-1:0];
            state_in       = S_SHIFT;
         end
         S_SHIFT: begin
            // Move entry idx+1 down to idx, one per cycle
            if (idx_plus1 < count_ff) begin
               wr_en   = 1'b1;
               wr_addr = idx_ff[ADDR_W-1:0];
               wr_data = rd_data;
               rd_addr = idx_plus2[ADDR_W-1:0];
               idx_in  = idx_plus1;
            end else begin
               count_in = count_ff - CNT_W'(1);
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Response register
   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_removed_in = rsp_removed_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_empty_in   = rsp_empty_ff;
      rsp_count_in   = rsp_count_ff;
      if (rsp_load) begin
         rsp_valid_in   = 1'b1;
         rsp_removed_in = res_removed_ff;
         rsp_status_in  = res_status_ff;
         rsp_empty_in   = (count_ff == '0);
         rsp_count_in   = count_wide[COUNT_OUT_W-1:0];
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff         <= idx_in;
      res_removed_ff <= res_removed_in;
      res_status_ff  <= res_status_in;
      rsp_removed_ff <= rsp_removed_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_empty_ff   <= rsp_empty_in;
      rsp_count_ff   <= rsp_count_in;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.removed_value = rsp_removed_ff;
   assign rsp_chan.status        = rsp_status_ff;
   assign rsp_chan.is_empty      = rsp_empty_ff;
   assign rsp_chan.entry_count   = rsp_count_ff;

   // Occupancy never passes the depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("occupancy above depth");

   // The close-up sweep stays inside the live entries
   a_shift_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHIFT) |-> (idx_ff < count_ff))
      else $error("close-up index past count");

   // A request transfer closes the request side on the next cycle
   a_busy_after_xfer: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> !req_chan.ready)
      else $error("ready while an item is in work");

   // An empty-queue error always reports an empty queue
   a_empty_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == ST_EMPTY) |-> (rsp_empty_ff && rsp_removed_ff == '0))
      else $error("empty error with entries or data");

endmodule

`default_nettype wire

// ----- hw/rtl/irq_rem.sv -----
// Bit-serial restoring remainder unit: dividend mod divisor, one bit per cycle.
`default_nettype none

module irq_rem import irq_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic [POS_W-1:0]               dividend,
   input  wire logic [$clog2(DEPTH+1)-1:0]     divisor,
   output logic                                done,
   output logic [$clog2(DEPTH+1)-1:0]          remainder
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int BIT_W = $clog2(POS_W);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [BIT_W-1:0]    bit_ff, bit_in;
   logic [POS_W-1:0]    quo_ff, quo_in;
   logic [CNT_W-1:0]    div_ff, div_in;
   logic [CNT_W:0]      rem_ff, rem_in;
   logic [CNT_W:0]      trial;

   // Shift in the next dividend bit and subtract when it fits
   always_comb begin
      trial   = {rem_ff[CNT_W-1:0], quo_ff[POS_W-1]};
      busy_in = busy_ff;
      done_in = 1'b0;
      bit_in  = bit_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         bit_in  = BIT_W'(POS_W - 1);
         quo_in  = dividend;
         div_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         quo_in = {quo_ff[POS_W-2:0], 1'b0};
         if (trial >= {1'b0, div_ff}) begin
            rem_in = trial - {1'b0, div_ff};
         end else begin
            rem_in = trial;
         end
         bit_in = bit_ff - 1'b1;
         if (bit_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      bit_ff <= bit_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff[CNT_W-1:0];

   // Result is always a proper residue of the latched divisor
   a_rem_below_div: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (rem_ff < {1'b0, div_ff}))
      else $error("remainder not below divisor");

   // Done follows the last iteration
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("done without a running division");

   // A new start never lands while a division is running
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !start)
      else $error("start while busy");

endmodule

`default_nettype wire

// ----- hw/rtl/irq_mem.sv -----
// Entry storage: one write port, one registered read port.
`default_nettype none

module irq_mem import irq_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  wire logic                      clock,
   input  wire logic                      wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]  wr_addr,
   input  wire logic [VALUE_W-1:0]        wr_data,
   input  wire logic [$clog2(DEPTH)-1:0]  rd_addr,
   output logic [VALUE_W-1:0]             rd_data
);

   logic [VALUE_W-1:0] entries_ff [DEPTH];
   logic [VALUE_W-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entries_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= entries_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- tb/indexed_removal_queue_top_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the indexed removal queue: random traffic with a queue predictor.

module indexed_removal_queue_top_test;
   import irq_pkg::*;

   localparam int QUEUE_DEPTH     = DEPTH_DEFAULT;
   localparam int RANDOM_REQUESTS = 1450;
   localparam int MAX_REPORTS     = 10;
   localparam int DRAIN_CYCLES    = 40;
   localparam int HOLD_CYCLES     = 200;

   typedef struct {
      logic                      action;
      logic signed [VALUE_W-1:0] value;
      logic [POS_W-1:0]          position;
   } queue_request_type;

   typedef struct {
      logic signed [VALUE_W-1:0] removed_value;
      logic [STATUS_W-1:0]       status;
      logic                      is_empty;
      logic [COUNT_OUT_W-1:0]    entry_count;
   } queue_reply_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   irq_req_if req_chan ();
   irq_rsp_if rsp_chan ();

   indexed_removal_queue_top #(.DEPTH(QUEUE_DEPTH)) uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Shadow copy of the queue contents
   logic signed [VALUE_W-1:0] shadow_entries [QUEUE_DEPTH];
   int unsigned               shadow_count = 0;

   queue_request_type request_backlog [$];
   queue_reply_type   awaited_replies [$];
   queue_request_type offered_request;

   int          requests_accepted = 0;
   int          replies_seen      = 0;
   int          mismatch_count    = 0;
   int unsigned send_wait         = 0;
   int unsigned recv_wait         = 0;
   bit          send_steady       = 1'b0;
   bit          recv_steady       = 1'b0;
   logic        hold_responses    = 1'b0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Apply one request to the shadow queue and return the reply it must produce
   function automatic queue_reply_type predict_queue_reply(queue_request_type req);
      queue_reply_type reply;
      int unsigned     offset;
      int unsigned     slot;
      int unsigned     i;
      reply.removed_value = '0;
      reply.status        = ST_OK;
      if (req.action == ACT_ENQUEUE) begin
         if (shadow_count >= QUEUE_DEPTH) begin
            reply.status = ST_FULL;
         end else begin
            shadow_entries[shadow_count] = req.value;
            shadow_count++;
         end
      end else if (shadow_count == 0) begin
         reply.status = ST_EMPTY;
      end else begin
         // position 0 aliases the head; larger positions wrap on the count
         offset = (req.position == '0) ? 0 : int'(req.position) - 1;
         slot   = offset % shadow_count;
         reply.removed_value = shadow_entries[slot];
         for (i = slot; i + 1 < shadow_count; i++) begin
            shadow_entries[i] = shadow_entries[i + 1];
         end
         shadow_count--;
      end
      reply.is_empty    = (shadow_count == 0);
      reply.entry_count = shadow_count[COUNT_OUT_W-1:0];
      return reply;
   endfunction

   function automatic int unsigned draw_gap(bit steady);
      return steady ? 0 : $urandom_range(0, 11);
   endfunction

   task automatic add_request(input logic action, input logic signed [VALUE_W-1:0] value,
                              input logic [POS_W-1:0] position);
      queue_request_type item;
      item.action   = action;
      item.value    = value;
      item.position = position;
      request_backlog.push_back(item);
   endtask

   function automatic logic [POS_W-1:0] pick_position();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return POS_W'(1);
         2:       return '1;
         3, 4, 5: return POS_W'($urandom_range(1, QUEUE_DEPTH + 1));
         default: return POS_W'($urandom_range(0, 65535));
      endcase
   endfunction

   // Request driver: one transfer per handshake, random gap between items
   always @(posedge clock) begin : request_driver
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            awaited_replies.push_back(predict_queue_reply(offered_request));
            requests_accepted++;
            send_wait = draw_gap(send_steady);
            if ($urandom_range(0, 39) == 0) send_steady = !send_steady;
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (send_wait != 0) begin
               send_wait--;
               req_chan.valid <= 1'b0;
            end else if (request_backlog.size() != 0) begin
               offered_request = request_backlog.pop_front();
               req_chan.action   <= offered_request.action;
               req_chan.value    <= offered_request.value;
               req_chan.position <= offered_request.position;
               req_chan.valid    <= 1'b1;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // Reply monitor: compare each transfer with the oldest prediction
   always @(posedge clock) begin : reply_monitor
      queue_reply_type observed;
      queue_reply_type wanted;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            observed.removed_value = rsp_chan.removed_value;
            observed.status        = rsp_chan.status;
            observed.is_empty      = rsp_chan.is_empty;
            observed.entry_count   = rsp_chan.entry_count;
            if (awaited_replies.size() == 0) begin
               if (mismatch_count < MAX_REPORTS)
                  $display("reply %0d: unexpected, got value=%0d status=%0d empty=%0d count=%0d",
                           replies_seen, observed.removed_value, observed.status,
                           observed.is_empty, observed.entry_count);
               mismatch_count++;
            end else begin
               wanted = awaited_replies.pop_front();
               if (observed.removed_value !== wanted.removed_value ||
                   observed.status        !== wanted.status ||
                   observed.is_empty      !== wanted.is_empty ||
                   observed.entry_count   !== wanted.entry_count) begin
                  if (mismatch_count < MAX_REPORTS)
                     $display({"reply %0d: expected value=%0d status=%0d empty=%0d count=%0d,",
                               " got value=%0d status=%0d empty=%0d count=%0d"},
                              replies_seen, wanted.removed_value, wanted.status,
                              wanted.is_empty, wanted.entry_count, observed.removed_value,
                              observed.status, observed.is_empty, observed.entry_count);
                  mismatch_count++;
               end
            end
            replies_seen++;
            recv_wait = draw_gap(recv_steady);
            if ($urandom_range(0, 39) == 0) recv_steady = !recv_steady;
         end else if (recv_wait != 0) begin
            recv_wait--;
         end
         rsp_chan.ready <= !hold_responses && (recv_wait == 0);
      end
   end

   // Long receiver stalls so the block backs up and stalls its input
   initial begin : reply_hold_off
      int round;
      for (round = 0; round < 2; round++) begin
         while (requests_accepted < 300 + 700 * round) @(posedge clock);
         hold_responses <= 1'b1;
         repeat (HOLD_CYCLES) @(posedge clock);
         hold_responses <= 1'b0;
      end
   end

   initial begin
      #2_000_000;
      $display("tb: failure");
      $finish;
   end

   initial begin : stimulus
      int                        n;
      int                        enqueue_pct;
      int                        total_requests;
      logic signed [VALUE_W-1:0] v;
      req_chan.valid    = 1'b0;
      req_chan.action   = ACT_ENQUEUE;
      req_chan.value    = '0;
      req_chan.position = '0;
      rsp_chan.ready    = 1'b0;

      // Removes on an empty queue
      add_request(ACT_REMOVE, $urandom, '0);
      add_request(ACT_REMOVE, $urandom, '1);
      // Extreme values
      add_request(ACT_ENQUEUE, 32'sh8000_0000, POS_W'($urandom_range(0, 65535)));
      add_request(ACT_ENQUEUE, 32'sh7fff_ffff, POS_W'($urandom_range(0, 65535)));
      add_request(ACT_ENQUEUE, -32'sd1, POS_W'($urandom_range(0, 65535)));
      add_request(ACT_ENQUEUE, '0, POS_W'($urandom_range(0, 65535)));
      add_request(ACT_ENQUEUE, 32'sd1, POS_W'($urandom_range(0, 65535)));
      // Position zero takes the head, a large position wraps
      add_request(ACT_REMOVE, $urandom, '0);
      add_request(ACT_REMOVE, $urandom, '1);
      // Fill to the brim, then enqueue on a full queue
      for (n = 0; n < QUEUE_DEPTH - 3; n++)
         add_request(ACT_ENQUEUE, $urandom, POS_W'($urandom_range(0, 65535)));
      add_request(ACT_ENQUEUE, $urandom, POS_W'($urandom_range(0, 65535)));
      // Tail of a full queue, then a position past the count wraps
      add_request(ACT_REMOVE, $urandom, POS_W'(QUEUE_DEPTH));
      add_request(ACT_REMOVE, $urandom, POS_W'(QUEUE_DEPTH + 1));

      // Random traffic in segments that lean toward full, toward empty or neither
      enqueue_pct = 50;
      for (n = 0; n < RANDOM_REQUESTS; n++) begin
         if (n % 48 == 0) begin
            case ($urandom_range(0, 4))
               0:       enqueue_pct = 10;
               1:       enqueue_pct = 30;
               2:       enqueue_pct = 50;
               3:       enqueue_pct = 70;
               default: enqueue_pct = 90;
            endcase
         end
         if ($urandom_range(0, 99) < enqueue_pct) begin
            case ($urandom_range(0, 15))
               0:       v = 32'sh8000_0000;
               1:       v = 32'sh7fff_ffff;
               2:       v = '0;
               3:       v = -32'sd1;
               default: v = $urandom;
            endcase
            add_request(ACT_ENQUEUE, v, POS_W'($urandom_range(0, 65535)));
         end else begin
            add_request(ACT_REMOVE, $urandom, pick_position());
         end
      end
      total_requests = request_backlog.size();

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (requests_accepted < total_requests) @(posedge clock);
      while (awaited_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && awaited_replies.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
